// ===== sv/psa_pkg.sv =====
// Shared types and constants for the polar surface area accumulator.
package psa_pkg;

  localparam int ContribW = 13;
  localparam int TotalW   = 24;

  localparam logic [6:0] ELEM_N = 7'd7;
  localparam logic [6:0] ELEM_O = 7'd8;
  localparam logic [6:0] ELEM_P = 7'd15;
  localparam logic [6:0] ELEM_S = 7'd16;

  localparam logic signed [3:0] CHG_ZERO = 4'sd0;
  localparam logic signed [3:0] CHG_POS  = 4'sd1;
  localparam logic signed [3:0] CHG_NEG  = -4'sd1;

  localparam logic [1:0] CFG_ZERO_UNCL    = 2'd0;
  localparam logic [1:0] CFG_DIV_SULPHUR  = 2'd1;
  localparam logic [1:0] CFG_ZERO_SULPHUR = 2'd2;
  localparam logic [1:0] CFG_ZERO_PHOS    = 2'd3;

  localparam logic signed [ContribW-1:0] CONTRIB_MAX = 13'sd4000;
  localparam logic signed [ContribW-1:0] CONTRIB_MIN = -13'sd1000;

  typedef struct packed {
    logic              zero_uncl;
    logic              div_sulphur;
    logic              zero_sulphur;
    logic              zero_phos;
  } cfg_t;

  typedef struct packed {
    logic [6:0]        element;
    logic              aromatic;
    logic signed [3:0] charge;
    logic [2:0]        hydrogens;
    logic [2:0]        nbr;
    logic [2:0]        nar;
    logic [2:0]        ns;
    logic [2:0]        nd;
    logic [2:0]        nt;
    logic              ring3;
    logic              last;
  } atom_t;

  typedef struct packed {
    logic signed [ContribW-1:0] contrib;
    logic                       uncl;
  } cls_t;

endpackage

// ===== sv/polar_surface_area_accumulator.sv =====
// Top level of the polar surface area accumulator: input register, config, result stage.
//
// An accepted atom is held in the input register, classified and summed, and its result
// is then registered in the result stage, where out_valid rises.
// Throughput: one atom per clock unless out_ready stalls; input and result registers form a
// two-stage pipeline, and the running total closes its feedback through one saturating add.
// Reset (rst_n low, synchronous) empties both stages, clears the running total to zero and
// returns the mode registers to zero_unclassified=0, divalent_sulphur_counts=1, others 0.
module polar_surface_area_accumulator (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic                                cfg_data,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [6:0]                          in_element,
  input  logic                                in_aromatic,
  input  logic signed [3:0]                   in_charge,
  input  logic [2:0]                          in_hydrogens,
  input  logic [2:0]                          in_neighbor_count,
  input  logic [2:0]                          in_aromatic_bond_count,
  input  logic [2:0]                          in_single_bond_count,
  input  logic [2:0]                          in_double_bond_count,
  input  logic [2:0]                          in_triple_bond_count,
  input  logic                                in_in_three_ring,
  input  logic                                in_last_atom,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [psa_pkg::ContribW-1:0] out_contribution,
  output logic signed [psa_pkg::TotalW-1:0]   out_running_total,
  output logic                                out_unclassified,
  output logic                                out_molecule_done
);

  psa_pkg::cfg_t  cfg_r;
  psa_pkg::atom_t atom_r;
  psa_pkg::cls_t  cls;
  logic           s1_valid_r;
  logic           s2_ready;
  logic           in_xfer;

  // Mode registers. Writes are always taken; the user must issue them only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_uncl    <= 1'b0;
      cfg_r.div_sulphur  <= 1'b1;
      cfg_r.zero_sulphur <= 1'b0;
      cfg_r.zero_phos    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        psa_pkg::CFG_ZERO_UNCL:    cfg_r.zero_uncl    <= cfg_data;
        psa_pkg::CFG_DIV_SULPHUR:  cfg_r.div_sulphur  <= cfg_data;
        psa_pkg::CFG_ZERO_SULPHUR: cfg_r.zero_sulphur <= cfg_data;
        psa_pkg::CFG_ZERO_PHOS:    cfg_r.zero_phos    <= cfg_data;
        default: ;
      endcase
    end
  end

  // The input register refills in the same cycle that its atom moves into the result
  // stage, so a stalled output only holds back the input once both stages are full.
  assign in_ready = !s1_valid_r || s2_ready;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      atom_r.element   <= in_element;
      atom_r.aromatic  <= in_aromatic;
      atom_r.charge    <= in_charge;
      atom_r.hydrogens <= in_hydrogens;
      atom_r.nbr       <= in_neighbor_count;
      atom_r.nar       <= in_aromatic_bond_count;
      atom_r.ns        <= in_single_bond_count;
      atom_r.nd        <= in_double_bond_count;
      atom_r.nt        <= in_triple_bond_count;
      atom_r.ring3     <= in_in_three_ring;
      atom_r.last      <= in_last_atom;
    end
  end

  // Fragment match for the atom sitting in the input register.
  psa_classify u_classify (
    .a   (atom_r),
    .cfg (cfg_r),
    .cls (cls)
  );

  // Saturating total and the result register feeding the output channel.
  psa_accum u_accum (
    .clk               (clk),
    .rst_n             (rst_n),
    .s_valid           (s1_valid_r),
    .s_ready           (s2_ready),
    .cls               (cls),
    .last              (atom_r.last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_contribution  (out_contribution),
    .out_running_total (out_running_total),
    .out_unclassified  (out_unclassified),
    .out_molecule_done (out_molecule_done)
  );

endmodule

// ===== sv/psa_classify.sv =====
// Fragment table match and fallback estimate for one registered atom.
module psa_classify (
  input  psa_pkg::atom_t a,
  input  psa_pkg::cfg_t  cfg,
  output psa_pkg::cls_t  cls
);

  logic                              polar;
  logic                              hit;
  logic signed [psa_pkg::ContribW-1:0] val;
  logic signed [14:0]                fb;
  logic signed [14:0]                raw;
  logic [10:0]                       h150;
  logic [12:0]                       nc820;
  logic                              c0, c1, cm;
  logic signed [14:0]                fb_n;

  assign c0 = (a.charge == psa_pkg::CHG_ZERO);
  assign c1 = (a.charge == psa_pkg::CHG_POS);
  assign cm = (a.charge == psa_pkg::CHG_NEG);

  // Nitrogen fallback: 3050 - 820 per connection + 150 per hydrogen.
  assign h150  = {8'b0, a.hydrogens} * 11'd150;
  assign nc820 = {10'b0, a.nbr} * 13'd820;
  assign fb_n  = 15'sd3050 + $signed({4'b0, h150}) - $signed({2'b0, nc820});

  always_comb begin
    polar = 1'b1;
    hit   = 1'b1;
    val   = '0;
    fb    = '0;
    if (a.element == psa_pkg::ELEM_N) begin
      fb = fb_n;
      if (a.aromatic) begin
        if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd2 && a.nar == 3'd2) val = 13'sd1289;
        else if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd3 && a.nar == 3'd3) val = 13'sd441;
        else if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd3 && a.nar == 3'd2 && a.ns == 3'd1)
          val = 13'sd493;
        else if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd3 && a.nar == 3'd2 && a.nd == 3'd1)
          val = 13'sd839;
        else if (c0 && a.hydrogens == 3'd1 && a.nbr == 3'd2 && a.nar == 3'd2) val = 13'sd1579;
        else if (c1 && a.hydrogens == 3'd0 && a.nbr == 3'd3 && a.nar == 3'd3) val = 13'sd410;
        else if (c1 && a.hydrogens == 3'd0 && a.nbr == 3'd3 && a.nar == 3'd2 && a.ns == 3'd1)
          val = 13'sd388;
        else if (c1 && a.hydrogens == 3'd1 && a.nbr == 3'd2 && a.nar == 3'd2) val = 13'sd1414;
        else hit = 1'b0;
      end else begin
        if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd3 && a.ns == 3'd3 && a.ring3)
          val = 13'sd301;
        else if (c0 && a.hydrogens == 3'd1 && a.nbr == 3'd2 && a.ns == 3'd2 && a.ring3)
          val = 13'sd2194;
        else if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd3 && a.ns == 3'd3) val = 13'sd324;
        else if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd2 && a.ns == 3'd1 && a.nd == 3'd1)
          val = 13'sd1236;
        else if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd1 && a.nt == 3'd1) val = 13'sd2379;
        else if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd3 && a.ns == 3'd1 && a.nd == 3'd2)
          val = 13'sd1168;
        else if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd2 && a.nd == 3'd1 && a.nt == 3'd1)
          val = 13'sd1360;
        else if (c0 && a.hydrogens == 3'd1 && a.nbr == 3'd2 && a.ns == 3'd2) val = 13'sd1203;
        else if (c0 && a.hydrogens == 3'd1 && a.nbr == 3'd1 && a.nd == 3'd1) val = 13'sd2385;
        else if (c0 && a.hydrogens == 3'd2 && a.nbr == 3'd1 && a.ns == 3'd1) val = 13'sd2602;
        else if (c1 && a.hydrogens == 3'd0 && a.nbr == 3'd4 && a.ns == 3'd4) val = 13'sd0;
        else if (c1 && a.hydrogens == 3'd0 && a.nbr == 3'd3 && a.ns == 3'd2 && a.nd == 3'd1)
          val = 13'sd301;
        else if (c1 && a.hydrogens == 3'd0 && a.nbr == 3'd2 && a.ns == 3'd1 && a.nt == 3'd1)
          val = 13'sd436;
        else if (c1 && a.hydrogens == 3'd1 && a.nbr == 3'd3 && a.ns == 3'd3) val = 13'sd444;
        else if (c1 && a.hydrogens == 3'd1 && a.nbr == 3'd2 && a.ns == 3'd1 && a.nd == 3'd1)
          val = 13'sd1397;
        else if (c1 && a.hydrogens == 3'd2 && a.nbr == 3'd2 && a.ns == 3'd2) val = 13'sd1661;
        else if (c1 && a.hydrogens == 3'd2 && a.nbr == 3'd1 && a.nd == 3'd1) val = 13'sd2559;
        else if (c1 && a.hydrogens == 3'd3 && a.nbr == 3'd1 && a.ns == 3'd1) val = 13'sd2764;
        else hit = 1'b0;
      end
    end else if (a.element == psa_pkg::ELEM_O) begin
      fb = 15'sd1000;
      if (a.aromatic) begin
        if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd2 && a.nar == 3'd2) val = 13'sd1314;
        else hit = 1'b0;
      end else begin
        if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd2 && a.ring3) val = 13'sd1253;
        else if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd2 && a.ns == 3'd2) val = 13'sd923;
        else if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd1 && a.nd == 3'd1) val = 13'sd1707;
        else if (c0 && a.hydrogens == 3'd1 && a.nbr == 3'd1 && a.ns == 3'd1) val = 13'sd2023;
        else if (cm && a.hydrogens == 3'd0 && a.nbr == 3'd1 && a.ns == 3'd1) val = 13'sd2306;
        else hit = 1'b0;
      end
    end else if (a.element == psa_pkg::ELEM_S && !cfg.zero_sulphur) begin
      fb = 15'sd2000;
      if (a.aromatic) begin
        // Aromatic sulphur always counts as matched; unlisted forms give zero.
        if (cfg.div_sulphur && c0 && a.hydrogens == 3'd0 && a.nbr == 3'd2 && a.nar == 3'd2)
          val = 13'sd2824;
        else if (cfg.div_sulphur && c0 && a.hydrogens == 3'd0 && a.nbr == 3'd3 &&
                 a.nar == 3'd2 && a.nd == 3'd1)
          val = 13'sd2170;
        else val = 13'sd0;
      end else begin
        if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd2 && a.ns == 3'd2)
          val = cfg.div_sulphur ? 13'sd2530 : 13'sd0;
        else if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd1 && a.nd == 3'd1) val = 13'sd3209;
        else if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd3 && a.ns == 3'd2 && a.nd == 3'd1)
          val = 13'sd1921;
        else if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd4 && a.ns == 3'd2 && a.nd == 3'd2)
          val = 13'sd838;
        else if (c0 && a.hydrogens == 3'd1 && a.nbr == 3'd1 && a.ns == 3'd1) val = 13'sd3880;
        else hit = 1'b0;
      end
    end else if (a.element == psa_pkg::ELEM_P && !cfg.zero_phos) begin
      fb = 15'sd1000;
      if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd3 && a.ns == 3'd3) val = 13'sd1359;
      else if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd2 && a.ns == 3'd1 && a.nd == 3'd1)
        val = 13'sd3414;
      else if (c0 && a.hydrogens == 3'd0 && a.nbr == 3'd4 && a.ns == 3'd3 && a.nd == 3'd1)
        val = 13'sd981;
      else if (c0 && a.hydrogens == 3'd1 && a.nbr == 3'd3 && a.ns == 3'd2 && a.nd == 3'd1)
        val = 13'sd2347;
      else hit = 1'b0;
    end else begin
      polar = 1'b0;
      hit   = 1'b0;
    end
  end

  always_comb begin
    if (!polar) begin
      raw = '0;
    end else if (hit) begin
      raw = {{2{val[psa_pkg::ContribW-1]}}, val};
    end else if (cfg.zero_uncl) begin
      raw = '0;
    end else begin
      raw = fb;
    end
    if (raw > 15'(psa_pkg::CONTRIB_MAX)) begin
      cls.contrib = psa_pkg::CONTRIB_MAX;
    end else if (raw < 15'(psa_pkg::CONTRIB_MIN)) begin
      cls.contrib = psa_pkg::CONTRIB_MIN;
    end else begin
      cls.contrib = raw[psa_pkg::ContribW-1:0];
    end
    cls.uncl = polar && !hit;
  end

endmodule

// ===== sv/psa_accum.sv =====
// Result register with the saturating per-molecule area accumulator.
module psa_accum (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                s_valid,
  output logic                                s_ready,
  input  psa_pkg::cls_t                       cls,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [psa_pkg::ContribW-1:0] out_contribution,
  output logic signed [psa_pkg::TotalW-1:0]   out_running_total,
  output logic                                out_unclassified,
  output logic                                out_molecule_done
);

  logic                                out_valid_r;
  logic signed [psa_pkg::TotalW-1:0]   sum_r, sum_nxt;
  logic signed [psa_pkg::TotalW-1:0]   total_r, total_nxt;
  logic signed [psa_pkg::ContribW-1:0] contrib_r;
  logic                                uncl_r, done_r;
  logic signed [psa_pkg::TotalW:0]     wide;
  logic                                load;

  assign s_ready = !out_valid_r || out_ready;
  assign load    = s_valid && s_ready;

  assign wide = {sum_r[psa_pkg::TotalW-1], sum_r}
              + {{(psa_pkg::TotalW-psa_pkg::ContribW+1){cls.contrib[psa_pkg::ContribW-1]}},
                 cls.contrib};

  always_comb begin
    // Overflow shows as the two top bits of the widened sum disagreeing.
    if (wide[psa_pkg::TotalW] != wide[psa_pkg::TotalW-1]) begin
      total_nxt = {wide[psa_pkg::TotalW], {(psa_pkg::TotalW-1){!wide[psa_pkg::TotalW]}}};
    end else begin
      total_nxt = wide[psa_pkg::TotalW-1:0];
    end
    sum_nxt = last ? '0 : total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sum_r       <= sum_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      contrib_r <= cls.contrib;
      total_r   <= total_nxt;
      uncl_r    <= cls.uncl;
      done_r    <= last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_contribution  = contrib_r;
  assign out_running_total = total_r;
  assign out_unclassified  = uncl_r;
  assign out_molecule_done = done_r;

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    load && last |=> sum_r == '0)
    else $error("accumulator not cleared after last atom");

  a_contrib_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (contrib_r <= psa_pkg::CONTRIB_MAX) && (contrib_r >= psa_pkg::CONTRIB_MIN))
    else $error("contribution outside clamp range");

  a_no_wrap_up: assert property (@(posedge clk) disable iff (!rst_n)
    load && !last && !cls.contrib[psa_pkg::ContribW-1] |=> sum_r >= $past(sum_r))
    else $error("running total wrapped on positive contribution");

  a_no_wrap_down: assert property (@(posedge clk) disable iff (!rst_n)
    load && !last && cls.contrib[psa_pkg::ContribW-1] |=> sum_r <= $past(sum_r))
    else $error("running total wrapped on negative contribution");

endmodule
